// ----- design/sida_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants for the decimal text converter
// Holds the controller states, the command and status bundles between the
// controller and the datapath, and the fixed widths and character codes.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W     = 4 * NUM_DIGITS;
  localparam int unsigned CHAR_W    = 6;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned NDIG_W    = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture a new value and clear the converter
    logic conv;         // one double-dabble step
    logic shift_digit;  // drop the top BCD digit
    logic sel_sign;     // present the minus sign on the output
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;    // this conversion step is the final one
    logic top_zero;     // the top BCD digit is zero
    logic one_digit;    // only one digit remains to be sent
    logic neg;          // the captured value is negative
  } status_t;

endpackage

// ----- design/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one signed 32-bit value into its decimal characters, sent one
// item at a time, most significant first, with a last flag on the final one.
// ----------------------------------------------------------------------------
// Each accepted value yields an optional minus sign (code 45) followed by one
// to ten digit characters (codes 48 to 57) with no leading zeros; zero gives a
// single '0', and the most negative value gives "-2147483648". The block works
// on one value at a time: in_ready is high only while it is idle. A value is
// captured, run through the shift-and-add-3 binary to BCD converter, trimmed of
// its leading zeros one digit at a time, and then sent one character at a time
// while out_ready is high. Dropped zeros and sent digits always add up to ten.
// The serial converter handles one magnitude bit per cycle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sida_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sida_pkg::CHAR_W-1:0]         out_char_code,
  output logic                                out_last
);

  // Command and status bundles between the sequencer and the datapath.
  sida_pkg::cmd_t    cmd;
  sida_pkg::status_t status;

  // The sequencer owns all handshakes; the datapath only holds the number
  // being converted and formats the character currently on offer. Because the
  // output character is taken straight from the held BCD register, it stays
  // stable for as long as the output item is stalled.
  sida_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_last),
    .status    (status),
    .cmd       (cmd)
  );

  sida_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .value     (in_value),
    .status    (status),
    .char_code (out_char_code)
  );

endmodule

// ----- design/sida_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_dp: conversion datapath
// Shift-and-add-3 binary to BCD converter, digit shifter for leading-zero
// removal and character output, and the output character formatting.
// ----------------------------------------------------------------------------
module sida_dp (
  input  logic                               clk,
  input  sida_pkg::cmd_t                     cmd,
  input  logic signed [sida_pkg::VALUE_W-1:0] value,
  output sida_pkg::status_t                  status,
  output logic [sida_pkg::CHAR_W-1:0]        char_code
);

  logic [sida_pkg::VALUE_W-1:0] bin_r,  bin_nxt;
  logic [sida_pkg::BCD_W-1:0]   bcd_r,  bcd_nxt;
  logic [sida_pkg::CNT_W-1:0]   cnt_r,  cnt_nxt;
  logic [sida_pkg::NDIG_W-1:0]  ndig_r, ndig_nxt;
  logic                         neg_r,  neg_nxt;
  logic [sida_pkg::BCD_W-1:0]   bcd_adj;
  logic [sida_pkg::VALUE_W-1:0] mag;

  // Two's complement magnitude; the most negative value maps to 2^31,
  // which still fits as an unsigned 32-bit number.
  assign mag = value[sida_pkg::VALUE_W-1] ? (~value + 1'b1) : value;

  always_comb begin
    for (int i = 0; i < sida_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] > 4'd4) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    ndig_nxt = ndig_r;
    neg_nxt  = neg_r;
    if (cmd.load) begin
      bin_nxt  = mag;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      ndig_nxt = sida_pkg::NDIG_W'(sida_pkg::NUM_DIGITS);
      neg_nxt  = value[sida_pkg::VALUE_W-1];
    end else if (cmd.conv) begin
      {bcd_nxt, bin_nxt} = {bcd_adj[sida_pkg::BCD_W-2:0], bin_r, 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.shift_digit) begin
      bcd_nxt  = {bcd_r[sida_pkg::BCD_W-5:0], 4'd0};
      ndig_nxt = ndig_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    ndig_r <= ndig_nxt;
    neg_r  <= neg_nxt;
  end

  assign status.conv_last = (cnt_r == sida_pkg::CNT_W'(sida_pkg::VALUE_W - 1));
  assign status.top_zero  = (bcd_r[sida_pkg::BCD_W-1 -: 4] == 4'd0);
  assign status.one_digit = (ndig_r == sida_pkg::NDIG_W'(1));
  assign status.neg       = neg_r;

  assign char_code = cmd.sel_sign ? sida_pkg::ASCII_MINUS
                   : (sida_pkg::ASCII_ZERO + {2'b00, bcd_r[sida_pkg::BCD_W-1 -: 4]});

endmodule

// ----- design/sida_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_ctrl: conversion sequencer
// Steps through capture, conversion, leading-zero removal and character
// output, and drives the handshakes of both channels.
// ----------------------------------------------------------------------------
module sida_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  input  sida_pkg::status_t status,
  output sida_pkg::cmd_t    cmd
);

  sida_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sida_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    unique case (state_r)
      sida_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sida_pkg::ST_CONV;
        end
      end
      sida_pkg::ST_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_last) begin
          state_nxt = sida_pkg::ST_TRIM;
        end
      end
      sida_pkg::ST_TRIM: begin
        // Drop leading zero digits, but always keep the last one.
        if (status.top_zero && !status.one_digit) begin
          cmd.shift_digit = 1'b1;
        end else if (status.neg) begin
          state_nxt = sida_pkg::ST_SIGN;
        end else begin
          state_nxt = sida_pkg::ST_DIGIT;
        end
      end
      sida_pkg::ST_SIGN: begin
        cmd.sel_sign = 1'b1;
        out_valid    = 1'b1;
        if (out_ready) begin
          state_nxt = sida_pkg::ST_DIGIT;
        end
      end
      sida_pkg::ST_DIGIT: begin
        out_valid = 1'b1;
        out_last  = status.one_digit;
        if (out_ready) begin
          cmd.shift_digit = 1'b1;
          if (status.one_digit) begin
            state_nxt = sida_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sida_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
